[src/bcci_pkg.sv]
// shared constants for the bicubic convolution interpolator
package bcci_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int OUT_BITS        = 31;

    localparam longint OUT_MAX = 64'sd1073741823;
    localparam longint OUT_MIN = -64'sd1073741824;

    // row index of the item that closes a window
    localparam logic [1:0] ROW_LAST = 2'd3;

endpackage

[src/bcci_queue.sv]
// small register queue between the row front end and the evaluation engine
module bcci_queue
    import bcci_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push && !o_full, i_pop && !o_empty})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/bcci_front.sv]
// front end: takes row transactions, masks nulls, forms the row polynomial coefficients
module bcci_front
    import bcci_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int EW          = 3 * (SAMPLE_BITS + 3) + SAMPLE_BITS + 2 * FRAC_BITS + 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_3,
    input  logic [3:0]                    i_null_mask,
    input  logic [FRAC_BITS-1:0]          i_frac_x,
    input  logic [FRAC_BITS-1:0]          i_frac_y,
    input  logic                          i_full,
    output logic                          o_push,
    output logic [EW-1:0]                 o_entry
);

    localparam int CB = SAMPLE_BITS + 3;

    logic [1:0]           r_row;
    logic signed [CB-1:0] w_s0, w_s1, w_s2, w_s3;
    logic signed [CB-1:0] w_c3, w_c2, w_c1;

    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    assign w_s0 = i_null_mask[0] ? '0 : CB'(i_sample_0);
    assign w_s1 = i_null_mask[1] ? '0 : CB'(i_sample_1);
    assign w_s2 = i_null_mask[2] ? '0 : CB'(i_sample_2);
    assign w_s3 = i_null_mask[3] ? '0 : CB'(i_sample_3);

    assign w_c3 = w_s3 - w_s2 + w_s1 - w_s0;
    assign w_c2 = w_s2 - w_s3 - (w_s1 <<< 1) + (w_s0 <<< 1);
    assign w_c1 = w_s2 - w_s0;

    assign o_entry = {w_c3, w_c2, w_c1, w_s1[SAMPLE_BITS-1:0], i_frac_x, i_frac_y, r_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (o_push) begin
            r_row <= r_row + 1'b1;
        end
    end

endmodule

[src/bcci_back.sv]
// evaluation engine: horner steps on shared multipliers, row store, column pass, output
module bcci_back
    import bcci_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int EW          = 3 * (SAMPLE_BITS + 3) + SAMPLE_BITS + 2 * FRAC_BITS + 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [EW-1:0]              i_entry,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    output logic signed [OUT_BITS-1:0] o_interp_value
);

    localparam int S  = SAMPLE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int CB = S + 3;
    localparam int CW = S + F + 8;
    localparam int SH = F - 8;
    localparam int XW = (CW + 1 > 32) ? CW + 1 : 32;
    localparam logic [2*F:0] HALF = (2*F+1)'(1) << (F - 1);
    localparam logic signed [XW-1:0] SAT_MAX = XW'(OUT_MAX);
    localparam logic signed [XW-1:0] SAT_MIN = XW'(OUT_MIN);

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_ADD, ST_COLSET, ST_FIN} t_state;

    t_state               r_state;
    logic signed [CW-1:0] r_acc;
    logic signed [CW-1:0] r_k1, r_k2, r_k3;
    logic signed [CW-1:0] r_part [3];
    logic signed [CW-1:0] r_phi;
    logic [2*F-1:0]       r_plo;
    logic [F-1:0]         r_t;
    logic [F-1:0]         r_ty;
    logic [1:0]           r_step;
    logic [1:0]           r_row;
    logic                 r_col;

    // queue entry fields
    logic signed [CB-1:0] e_c3, e_c2, e_c1;
    logic signed [S-1:0]  e_s1;
    logic [F-1:0]         e_fx, e_fy;
    logic [1:0]           e_row;

    logic signed [CW-F-1:0] w_hi;
    logic signed [CW:0]     w_phi_full;
    logic [2*F:0]           w_rsum;
    logic signed [CW-1:0]   w_coef;
    logic signed [CW-1:0]   w_next;
    logic signed [CW-1:0]   w_p3;
    logic signed [CW:0]     w_shift;
    logic signed [XW-1:0]   w_v;
    logic signed [XW-1:0]   w_sat;

    assign {e_c3, e_c2, e_c1, e_s1, e_fx, e_fy, e_row} = i_entry;

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // acc*t split as hi*t + round(lo*t), keeps each product narrow
    assign w_hi       = r_acc[CW-1:F];
    assign w_phi_full = w_hi * $signed({1'b0, r_t});
    assign w_rsum     = {1'b0, r_plo} + HALF;

    always_comb begin
        case (r_step)
            2'd0:    w_coef = r_k1;
            2'd1:    w_coef = r_k2;
            default: w_coef = r_k3;
        endcase
    end

    assign w_next = r_phi + CW'(w_rsum[2*F:F]) + w_coef;
    assign w_p3   = r_acc;

    // final Q.F to Q.8 with round half up
    generate
        if (SH > 0) begin : g_round
            localparam logic signed [CW:0] HALF_OUT = (CW+1)'(1) << (SH - 1);
            assign w_shift = ($signed({r_acc[CW-1], r_acc}) + HALF_OUT) >>> SH;
        end else begin : g_noround
            assign w_shift = $signed({r_acc[CW-1], r_acc});
        end
    endgenerate

    assign w_v   = XW'(w_shift);
    assign w_sat = (w_v > SAT_MAX) ? SAT_MAX : ((w_v < SAT_MIN) ? SAT_MIN : w_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    if (r_step != 2'd2) begin
                        r_state <= ST_MUL;
                    end else if (r_col) begin
                        r_state <= ST_FIN;
                    end else if (r_row == ROW_LAST) begin
                        r_state <= ST_COLSET;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_COLSET: begin
                    r_state <= ST_MUL;
                end
                ST_FIN: begin
                    o_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_acc  <= {{(CW-CB-F){e_c3[CB-1]}}, e_c3, {F{1'b0}}};
                r_k1   <= {{(CW-CB-F){e_c2[CB-1]}}, e_c2, {F{1'b0}}};
                r_k2   <= {{(CW-CB-F){e_c1[CB-1]}}, e_c1, {F{1'b0}}};
                r_k3   <= {{(CW-S-F){e_s1[S-1]}}, e_s1, {F{1'b0}}};
                r_t    <= e_fx;
                r_ty   <= e_fy;
                r_row  <= e_row;
                r_step <= 2'd0;
                r_col  <= 1'b0;
            end
            ST_MUL: begin
                r_phi <= w_phi_full[CW-1:0];
                r_plo <= r_acc[F-1:0] * r_t;
            end
            ST_ADD: begin
                r_acc  <= w_next;
                r_step <= r_step + 1'b1;
                if (r_step == 2'd2 && !r_col) begin
                    case (r_row)
                        2'd0:    r_part[0] <= w_next;
                        2'd1:    r_part[1] <= w_next;
                        2'd2:    r_part[2] <= w_next;
                        default: ;
                    endcase
                end
            end
            ST_COLSET: begin
                // column pass over the stored rows and the row just finished
                r_acc  <= w_p3 - r_part[2] + r_part[1] - r_part[0];
                r_k1   <= r_part[2] - w_p3 - (r_part[1] <<< 1) + (r_part[0] <<< 1);
                r_k2   <= r_part[2] - r_part[0];
                r_k3   <= r_part[1];
                r_t    <= r_ty;
                r_step <= 2'd0;
                r_col  <= 1'b1;
            end
            ST_FIN: begin
                o_interp_value <= w_sat[OUT_BITS-1:0];
            end
            default: ;
        endcase
    end

endmodule

[src/bicubic_convolution_interpolator.sv]
// top level: 4x4 bicubic convolution interpolator, one window row per transaction
// the engine takes each row in three horner steps, a multiply state then an add state each,
// on shared multipliers; after the fourth row it runs a column pass over the four row results
// and then registers the result with its strobe; a 2-entry queue lets start be taken while
// the engine works; busy is high while the queue is full
// reset clears the row counter, queue and engine state; the result strobe cannot be held off
module bicubic_convolution_interpolator
    import bcci_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_3,
    input  logic [3:0]                    i_null_mask,
    input  logic [FRAC_BITS-1:0]          i_frac_x,
    input  logic [FRAC_BITS-1:0]          i_frac_y,
    output logic                          o_valid,
    output logic signed [OUT_BITS-1:0]    o_interp_value
);

    localparam int EW = 3 * (SAMPLE_BITS + 3) + SAMPLE_BITS + 2 * FRAC_BITS + 2;

    logic          w_push;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    logic [EW-1:0] w_in_entry;
    logic [EW-1:0] w_out_entry;

    bcci_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .EW          (EW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_sample_0  (i_sample_0),
        .i_sample_1  (i_sample_1),
        .i_sample_2  (i_sample_2),
        .i_sample_3  (i_sample_3),
        .i_null_mask (i_null_mask),
        .i_frac_x    (i_frac_x),
        .i_frac_y    (i_frac_y),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_entry     (w_in_entry)
    );

    bcci_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_in_entry),
        .i_pop   (w_pop),
        .o_data  (w_out_entry),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    bcci_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .EW          (EW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_entry        (w_out_entry),
        .i_empty        (w_empty),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_interp_value (o_interp_value)
    );

endmodule

[sim/tb.sv]
// testbench for the bicubic convolution interpolator: row stream against a bit-exact predictor
`timescale 1ns / 100ps

module tb;
    import bcci_pkg::*;

    localparam int SB           = SAMPLE_BITS_DEF;
    localparam int FB           = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [SB-1:0]    i_sample_0;
    logic signed [SB-1:0]    i_sample_1;
    logic signed [SB-1:0]    i_sample_2;
    logic signed [SB-1:0]    i_sample_3;
    logic [3:0]              i_null_mask;
    logic [FB-1:0]           i_frac_x;
    logic [FB-1:0]           i_frac_y;
    logic                    o_valid;
    logic signed [OUT_BITS-1:0] o_interp_value;

    // predictor state
    longint                  row_store [3];
    logic [1:0]              row_idx = 2'd0;
    logic signed [OUT_BITS-1:0] interp_expected [$];

    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    int                      idle_pct = 0;

    bicubic_convolution_interpolator DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_0     (i_sample_0),
        .i_sample_1     (i_sample_1),
        .i_sample_2     (i_sample_2),
        .i_sample_3     (i_sample_3),
        .i_null_mask    (i_null_mask),
        .i_frac_x       (i_frac_x),
        .i_frac_y       (i_frac_y),
        .o_valid        (o_valid),
        .o_interp_value (o_interp_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // acc * t / 2^FB, half rounded up, split so nothing overflows
    function automatic longint frac_mul(input longint acc, input longint t);
        longint hi;
        longint lo;
        hi = acc >>> FB;
        lo = acc - (hi <<< FB);
        return hi * t + ((lo * t + (longint'(1) <<< (FB - 1))) >>> FB);
    endfunction

    // horner form of the a = -1 cubic convolution kernel
    function automatic longint cubic_eval(input longint p0, input longint p1,
                                          input longint p2, input longint p3,
                                          input longint t);
        longint c3;
        longint c2;
        longint c1;
        longint acc;
        c3  = p3 - p2 + p1 - p0;
        c2  = p2 - p3 - 2 * p1 + 2 * p0;
        c1  = p2 - p0;
        acc = frac_mul(c3, t) + c2;
        acc = frac_mul(acc, t) + c1;
        acc = frac_mul(acc, t) + p1;
        return acc;
    endfunction

    function automatic longint scaled_sample(input logic signed [SB-1:0] s, input logic is_null);
        if (is_null)
            return 0;
        return longint'(s) <<< FB;
    endfunction

    task automatic report_error(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("error at cycle %0d: %s", cycle_count, what);
    endtask

    // predicts on each accepted row and checks each result strobe
    always @(posedge i_clk) begin : monitor
        longint row_val;
        longint col_val;
        logic signed [OUT_BITS-1:0] want;
        if (i_rst_n) begin
            if (start && !busy) begin
                row_val = cubic_eval(scaled_sample(i_sample_0, i_null_mask[0]),
                                     scaled_sample(i_sample_1, i_null_mask[1]),
                                     scaled_sample(i_sample_2, i_null_mask[2]),
                                     scaled_sample(i_sample_3, i_null_mask[3]),
                                     longint'(i_frac_x));
                if (row_idx != ROW_LAST) begin
                    row_store[row_idx] = row_val;
                    row_idx = row_idx + 2'd1;
                end else begin
                    col_val = cubic_eval(row_store[0], row_store[1], row_store[2], row_val,
                                         longint'(i_frac_y));
                    col_val = (col_val + (longint'(1) <<< (FB - 9))) >>> (FB - 8);
                    if (col_val > OUT_MAX)
                        col_val = OUT_MAX;
                    if (col_val < OUT_MIN)
                        col_val = OUT_MIN;
                    interp_expected.push_back(col_val[OUT_BITS-1:0]);
                    row_idx = 2'd0;
                end
            end
            if (o_valid) begin
                if (interp_expected.size() == 0) begin
                    report_error($sformatf("result %0d with none expected", o_interp_value));
                end else begin
                    want = interp_expected.pop_front();
                    if (o_interp_value !== want)
                        report_error($sformatf("interp_value expected %0d actual %0d",
                                               want, o_interp_value));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one row transaction; start stays high into the next call unless a gap is drawn
    task automatic send_row(input logic signed [SB-1:0] s0, input logic signed [SB-1:0] s1,
                            input logic signed [SB-1:0] s2, input logic signed [SB-1:0] s3,
                            input logic [3:0] mask, input logic [FB-1:0] fx,
                            input logic [FB-1:0] fy);
        int gap;
        start       <= 1'b1;
        i_sample_0  <= s0;
        i_sample_1  <= s1;
        i_sample_2  <= s2;
        i_sample_3  <= s3;
        i_null_mask <= mask;
        i_frac_x    <= fx;
        i_frac_y    <= fy;
        do @(posedge i_clk); while (busy);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(30, 1) : $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            default: return SB'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [FB-1:0] rand_frac();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(FB-1){1'b0}}};
            default: return FB'($urandom_range(65535));
        endcase
    endfunction

    task automatic test_directed();
        logic signed [SB-1:0] pos_max;
        logic signed [SB-1:0] neg_max;
        pos_max = {1'b0, {(SB-1){1'b1}}};
        neg_max = {1'b1, {(SB-1){1'b0}}};
        idle_pct = 0;
        // zero window
        repeat (4) send_row('0, '0, '0, '0, 4'h0, '0, '0);
        // flat extremes at largest and half offsets
        repeat (4) send_row(pos_max, pos_max, pos_max, pos_max, 4'h0, '1, '1);
        repeat (4) send_row(neg_max, neg_max, neg_max, neg_max, 4'h0, 16'h8000, 16'h8000);
        // outer samples against inner samples at the extremes, largest overshoot of the kernel
        send_row(pos_max, neg_max, neg_max, pos_max, 4'h0, 16'h8000, 16'h8000);
        send_row(neg_max, pos_max, pos_max, neg_max, 4'h0, 16'h8000, 16'h8000);
        send_row(neg_max, pos_max, pos_max, neg_max, 4'h0, 16'h8000, 16'h8000);
        send_row(pos_max, neg_max, neg_max, pos_max, 4'h0, 16'h8000, 16'h8000);
        // null samples, including a fully null row
        send_row(pos_max, pos_max, pos_max, pos_max, 4'hF, rand_frac(), '0);
        send_row(neg_max, neg_max, neg_max, neg_max, 4'h1, rand_frac(), '0);
        send_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 4'h6,
                 rand_frac(), '0);
        send_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(), 4'h8,
                 rand_frac(), 16'h4000);
        // zero offsets pass sample 1 of row 1 straight through
        repeat (4) send_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                            4'h0, '0, '0);
    endtask

    task automatic test_random(input int windows, input int pct);
        logic [FB-1:0] fx;
        logic [FB-1:0] fy;
        idle_pct = pct;
        repeat (windows) begin
            // one x offset per window most of the time, as a real resampler would send
            fx = rand_frac();
            fy = rand_frac();
            repeat (4) begin
                send_row(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                         ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'h0,
                         ($urandom_range(4) == 0) ? rand_frac() : fx,
                         ($urandom_range(4) == 0) ? rand_frac() : fy);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_sample_0  <= '0;
        i_sample_1  <= '0;
        i_sample_2  <= '0;
        i_sample_3  <= '0;
        i_null_mask <= '0;
        i_frac_x    <= '0;
        i_frac_y    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(140, 0);
        test_random(140, 56);
        test_random(140, 30);

        start <= 1'b0;
        while (interp_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
